FILE: hw/rtl/gcrb_pkg.sv
`timescale 1ns / 1ps

package gcrb_pkg;

   // field widths
   localparam int WORLD_W = 24;
   localparam int SIZE_W  = 23;
   localparam int COUNT_W = 7;   // effective cell counts, up to 64
   localparam int COORD_W = 6;   // cell coordinates, 0 to 63
   localparam int QUOT_W  = 7;   // saturated quotient
   localparam int FRAC_W  = 6;   // quotient bits resolved below saturation

   localparam logic [QUOT_W-1:0] QUOT_SAT = QUOT_W'(64);
   localparam logic [2:0]        STEP_TOP = 3'(FRAC_W);

   // range queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   // register map
   typedef enum logic [2:0] {
      REG_ORIGIN_X    = 3'd0,
      REG_ORIGIN_Y    = 3'd1,
      REG_ORIGIN_Z    = 3'd2,
      REG_CELL_SIZE_X = 3'd3,
      REG_CELL_SIZE_Y = 3'd4,
      REG_CELL_SIZE_Z = 3'd5,
      REG_CELLS_X     = 3'd6,
      REG_CELLS_Y     = 3'd7
   } reg_idx_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_START,
      F_WAIT,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_MUL,
      B_BASE,
      B_EMIT
   } back_state_type;

   typedef struct packed {
      logic signed [WORLD_W-1:0] box_min_x;
      logic signed [WORLD_W-1:0] box_min_y;
      logic signed [WORLD_W-1:0] box_min_z;
      logic signed [WORLD_W-1:0] box_max_x;
      logic signed [WORLD_W-1:0] box_max_y;
      logic signed [WORLD_W-1:0] box_max_z;
   } box_type;

   typedef struct packed {
      logic [5:0] cell_index;
      logic [2:0] cell_col;
      logic [2:0] cell_row;
      logic       last;
   } rsp_type;

   // effective grid setup, sizes never zero and counts already clamped
   typedef struct packed {
      logic [WORLD_W-1:0] origin_x;
      logic [WORLD_W-1:0] origin_y;
      logic [WORLD_W-1:0] origin_z;
      logic [SIZE_W-1:0]  size_x;
      logic [SIZE_W-1:0]  size_y;
      logic [SIZE_W-1:0]  size_z;
      logic [COUNT_W-1:0] cells_x;
      logic [COUNT_W-1:0] cells_y;
      logic [COUNT_W-1:0] cells_z;
   } grid_cfg_type;

   // truncated quotient: neg set when the quotient is below zero
   typedef struct packed {
      logic              neg;
      logic [QUOT_W-1:0] q;
   } quot_type;

   // clamped cell range of one box
   typedef struct packed {
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] ex;
      logic [COORD_W-1:0] sy;
      logic [COORD_W-1:0] ey;
      logic [COORD_W-1:0] sz;
      logic [COORD_W-1:0] ez;
   } range_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic               full;
      logic               empty;
      logic [LEVEL_W-1:0] level;
   } queue_stat_type;

endpackage

FILE: hw/rtl/gcrb_req_if.sv
`timescale 1ns / 1ps

interface gcrb_req_if import gcrb_pkg::*;;
   logic    valid;
   logic    ready;
   box_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/gcrb_rsp_if.sv
`timescale 1ns / 1ps

interface gcrb_rsp_if import gcrb_pkg::*;;
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/gcrb_div.sv
`timescale 1ns / 1ps

module gcrb_div import gcrb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WORLD_W-1:0] value,
   input  logic [WORLD_W-1:0] origin,
   input  logic [SIZE_W-1:0]  size,
   output logic               busy,
   output quot_type           result
);

   localparam int SH_W = SIZE_W + FRAC_W;

   logic [WORLD_W-1:0] rem_ff, rem_in;
   logic [2:0]         step_ff, step_in;
   logic [FRAC_W-1:0]  q_ff, q_in;
   logic               sat_ff, sat_in;
   logic               neg_ff, neg_in;
   logic               busy_ff, busy_in;

   logic [WORLD_W:0]   off;
   logic [WORLD_W-1:0] mag;
   logic [SH_W-1:0]    div_sh;
   logic               ge;

   // offset from origin, then one quotient bit per cycle on the magnitude
   always_comb begin
      off    = {value[WORLD_W-1], value} - {origin[WORLD_W-1], origin};
      mag    = off[WORLD_W] ? WORLD_W'(-off) : off[WORLD_W-1:0];
      div_sh = SH_W'(size) << step_ff;
      ge     = SH_W'(rem_ff) >= div_sh;

      rem_in  = rem_ff;
      step_in = step_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;

      if (start) begin
         rem_in  = mag;
         neg_in  = off[WORLD_W];
         step_in = STEP_TOP;
         q_in    = '0;
         sat_in  = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff - 3'd1;
         if (step_ff == STEP_TOP) begin
            // quotient at or above the largest count: stop early
            if (ge) begin
               sat_in  = 1'b1;
               busy_in = 1'b0;
            end
         end else begin
            if (ge) begin
               rem_in           = rem_ff - WORLD_W'(div_sh);
               q_in[step_ff]    = 1'b1;
            end
            if (step_ff == 3'd0) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff  <= rem_in;
      step_ff <= step_in;
      q_ff    <= q_in;
      sat_ff  <= sat_in;
      neg_ff  <= neg_in;
   end

   assign busy       = busy_ff;
   assign result.q   = sat_ff ? QUOT_SAT : {1'b0, q_ff};
   assign result.neg = neg_ff && (sat_ff || (q_ff != '0));

endmodule

FILE: hw/rtl/gcrb_front.sv
`timescale 1ns / 1ps

module gcrb_front import gcrb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  grid_cfg_type  cfg,
   gcrb_req_if.sink      req_ch,
   input  logic          q_full,
   output logic          q_push,
   output range_type     q_data
);

   front_state_type state_ff, state_in;
   axis_type        axis_ff, axis_in;
   box_type         box_ff, box_in;
   range_type       range_ff, range_in;
   logic            reject_ff, reject_in;

   logic               div_start;
   logic [WORLD_W-1:0] lo_val, hi_val, org;
   logic [SIZE_W-1:0]  size;
   logic [COUNT_W-1:0] count;
   logic               lo_busy, hi_busy;
   quot_type           lo_q, hi_q;

   logic               axis_reject;
   logic [QUOT_W-1:0]  s_q, e_q;

   // operands of the axis at work
   always_comb begin
      unique case (axis_ff)
         AXIS_X: begin
            lo_val = box_ff.box_min_x;
            hi_val = box_ff.box_max_x;
            org    = cfg.origin_x;
            size   = cfg.size_x;
            count  = cfg.cells_x;
         end
         AXIS_Y: begin
            lo_val = box_ff.box_min_y;
            hi_val = box_ff.box_max_y;
            org    = cfg.origin_y;
            size   = cfg.size_y;
            count  = cfg.cells_y;
         end
         AXIS_Z: begin
            lo_val = box_ff.box_min_z;
            hi_val = box_ff.box_max_z;
            org    = cfg.origin_z;
            size   = cfg.size_z;
            count  = cfg.cells_z;
         end
         default: begin
            lo_val = '0;
            hi_val = '0;
            org    = '0;
            size   = SIZE_W'(1);
            count  = COUNT_W'(1);
         end
      endcase
   end

   gcrb_div u_div_lo (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .value  (lo_val),
      .origin (org),
      .size   (size),
      .busy   (lo_busy),
      .result (lo_q)
   );

   gcrb_div u_div_hi (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .value  (hi_val),
      .origin (org),
      .size   (size),
      .busy   (hi_busy),
      .result (hi_q)
   );

   // reject test and clamp of one axis
   always_comb begin
      axis_reject = (!lo_q.neg && (lo_q.q >= QUOT_W'(count))) || hi_q.neg;
      s_q = lo_q.neg ? '0 : lo_q.q;
      e_q = (hi_q.q >= QUOT_W'(count)) ? QUOT_W'(count - COUNT_W'(1)) : hi_q.q;
   end

   // sequencer over the three axes
   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      box_in    = box_ff;
      range_in  = range_ff;
      reject_in = reject_ff;
      div_start = 1'b0;
      q_push    = 1'b0;

      unique case (state_ff)
         F_IDLE: begin
            if (req_ch.valid) begin
               box_in    = req_ch.payload;
               axis_in   = AXIS_X;
               reject_in = 1'b0;
               state_in  = F_START;
            end
         end
         F_START: begin
            div_start = 1'b1;
            state_in  = F_WAIT;
         end
         F_WAIT: begin
            if (!lo_busy && !hi_busy) begin
               if (axis_reject || (s_q > e_q)) begin
                  reject_in = 1'b1;
               end
               unique case (axis_ff)
                  AXIS_X: begin
                     range_in.sx = COORD_W'(s_q);
                     range_in.ex = COORD_W'(e_q);
                  end
                  AXIS_Y: begin
                     range_in.sy = COORD_W'(s_q);
                     range_in.ey = COORD_W'(e_q);
                  end
                  default: begin
                     range_in.sz = COORD_W'(s_q);
                     range_in.ez = COORD_W'(e_q);
                  end
               endcase
               if (axis_ff == AXIS_Z) begin
                  state_in = F_PUSH;
               end else begin
                  axis_in  = (axis_ff == AXIS_X) ? AXIS_Y : AXIS_Z;
                  state_in = F_START;
               end
            end
         end
         F_PUSH: begin
            if (reject_ff) begin
               state_in = F_IDLE;
            end else if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      axis_ff   <= axis_in;
      box_ff    <= box_in;
      range_ff  <= range_in;
      reject_ff <= reject_in;
   end

   assign req_ch.ready = (state_ff == F_IDLE);
   assign q_data       = range_ff;

endmodule

FILE: hw/rtl/gcrb_queue.sv
`timescale 1ns / 1ps

module gcrb_queue import gcrb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  range_type      push_data,
   input  logic           pop,
   output logic           pop_valid,
   output range_type      pop_data,
   output logic           full,
   output queue_stat_type stat
);

   range_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [LEVEL_W-1:0] level_ff;

   // pointer and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            level_ff <= level_ff + LEVEL_W'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - LEVEL_W'(1);
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid  = (level_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign full       = (level_ff == LEVEL_W'(QUEUE_DEPTH));
   assign stat.push  = push;
   assign stat.pop   = pop;
   assign stat.full  = full;
   assign stat.empty = !pop_valid;
   assign stat.level = level_ff;

endmodule

FILE: hw/rtl/gcrb_back.sv
`timescale 1ns / 1ps

module gcrb_back import gcrb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  grid_cfg_type  cfg,
   input  logic          q_valid,
   input  range_type     q_data,
   output logic          q_pop,
   gcrb_rsp_if.source    rsp_ch
);

   back_state_type     state_ff, state_in;
   range_type          rng_ff, rng_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [5:0]         n_ff, n_in;
   logic [5:0]         stride_ff, stride_in;  // cells per z plane, mod 64
   logic [5:0]         r0_ff, r0_in;          // sy * cx, mod 64
   logic [5:0]         plane_ff, plane_in;    // z * cx * cy, mod 64
   logic [5:0]         row_ff, row_in;        // z * cx * cy + y * cx, mod 64
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [5:0]  cx6, cy6;
   logic [11:0] prod_a, prod_b;
   logic        load, at_end;

   always_comb begin
      cx6    = cfg.cells_x[5:0];
      cy6    = cfg.cells_y[5:0];
      prod_a = (state_ff == B_MUL) ? cx6 * cy6 : rng_ff.sz * stride_ff;
      prod_b = rng_ff.sy * cx6;
      at_end = (x_ff == rng_ff.ex) && (y_ff == rng_ff.ey) && (z_ff == rng_ff.ez);
   end

   // scan z outer, y, x inner; one result a cycle to the output when free
   always_comb begin
      state_in     = state_ff;
      rng_in       = rng_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      n_in         = n_ff;
      stride_in    = stride_ff;
      r0_in        = r0_ff;
      plane_in     = plane_ff;
      row_in       = row_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      q_pop        = 1'b0;
      load         = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               rng_in   = q_data;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            stride_in = prod_a[5:0];
            r0_in     = prod_b[5:0];
            state_in  = B_BASE;
         end
         B_BASE: begin
            plane_in = prod_a[5:0];
            row_in   = prod_a[5:0] + r0_ff;
            x_in     = rng_ff.sx;
            y_in     = rng_ff.sy;
            z_in     = rng_ff.sz;
            n_in     = '0;
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load                = 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_in.cell_index   = row_ff + x_ff;
               rsp_in.cell_col     = x_ff[2:0];
               rsp_in.cell_row     = y_ff[2:0];
               rsp_in.last         = at_end || (n_ff == 6'd63);
               n_in                = n_ff + 6'd1;
               if (rsp_in.last) begin
                  state_in = B_IDLE;
               end else if (x_ff != rng_ff.ex) begin
                  x_in = x_ff + COORD_W'(1);
               end else if (y_ff != rng_ff.ey) begin
                  x_in   = rng_ff.sx;
                  y_in   = y_ff + COORD_W'(1);
                  row_in = row_ff + cx6;
               end else begin
                  x_in     = rng_ff.sx;
                  y_in     = rng_ff.sy;
                  z_in     = z_ff + COORD_W'(1);
                  plane_in = plane_ff + stride_ff;
                  row_in   = plane_ff + stride_ff + r0_ff;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rng_ff    <= rng_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      n_ff      <= n_in;
      stride_ff <= stride_in;
      r0_ff     <= r0_in;
      plane_ff  <= plane_in;
      row_ff    <= row_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

endmodule

FILE: hw/rtl/grid_cell_range_binner.sv
`timescale 1ns / 1ps
// front: per box, three axis passes over two dividers shared by all axes
// back: setup states B_MUL and B_BASE after the pop, then one cell result per cycle while rsp is taken
// queue of two ranges between, so the front can work on the next box while the back emits
// reset: synchronous, clears control state and loads config defaults

module grid_cell_range_binner import gcrb_pkg::*; #(
   parameter int MAX_CELLS_X  = 8,
   parameter int MAX_CELLS_Y  = 8,
   parameter int GRID_Z_CELLS = 1
) (
   input  logic        clock,
   input  logic        reset,
   gcrb_req_if.sink    req_ch,
   gcrb_rsp_if.source  rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [WORLD_W-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [SIZE_W-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [3:0]         cells_x_ff, cells_y_ff;

   reg_idx_type    reg_idx;
   logic           csr_wr;
   grid_cfg_type   cfg;
   logic           q_push, q_pop, q_full, q_valid;
   range_type      push_data, pop_data;
   queue_stat_type q_stat;

   assign pready  = 1'b1;
   assign reg_idx = reg_idx_type'(paddr[4:2]);
   assign csr_wr  = psel && penable && pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         size_x_ff   <= SIZE_W'(100000);
         size_y_ff   <= SIZE_W'(100000);
         size_z_ff   <= SIZE_W'(100000);
         cells_x_ff  <= 4'd1;
         cells_y_ff  <= 4'd1;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_ORIGIN_X:    origin_x_ff <= pwdata[WORLD_W-1:0];
            REG_ORIGIN_Y:    origin_y_ff <= pwdata[WORLD_W-1:0];
            REG_ORIGIN_Z:    origin_z_ff <= pwdata[WORLD_W-1:0];
            REG_CELL_SIZE_X: size_x_ff   <= pwdata[SIZE_W-1:0];
            REG_CELL_SIZE_Y: size_y_ff   <= pwdata[SIZE_W-1:0];
            REG_CELL_SIZE_Z: size_z_ff   <= pwdata[SIZE_W-1:0];
            REG_CELLS_X:     cells_x_ff  <= pwdata[3:0];
            REG_CELLS_Y:     cells_y_ff  <= pwdata[3:0];
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_idx)
         REG_ORIGIN_X:    prdata = 32'(origin_x_ff);
         REG_ORIGIN_Y:    prdata = 32'(origin_y_ff);
         REG_ORIGIN_Z:    prdata = 32'(origin_z_ff);
         REG_CELL_SIZE_X: prdata = 32'(size_x_ff);
         REG_CELL_SIZE_Y: prdata = 32'(size_y_ff);
         REG_CELL_SIZE_Z: prdata = 32'(size_z_ff);
         REG_CELLS_X:     prdata = 32'(cells_x_ff);
         REG_CELLS_Y:     prdata = 32'(cells_y_ff);
      endcase
   end

   // effective grid: zero size acts as one, x/y counts clamped to 1..max, z fixed
   always_comb begin
      cfg.origin_x = origin_x_ff;
      cfg.origin_y = origin_y_ff;
      cfg.origin_z = origin_z_ff;
      cfg.size_x   = (size_x_ff == '0) ? SIZE_W'(1) : size_x_ff;
      cfg.size_y   = (size_y_ff == '0) ? SIZE_W'(1) : size_y_ff;
      cfg.size_z   = (size_z_ff == '0) ? SIZE_W'(1) : size_z_ff;
      cfg.cells_x  = (cells_x_ff == '0) ? COUNT_W'(1) : COUNT_W'(cells_x_ff);
      if (cfg.cells_x > COUNT_W'(MAX_CELLS_X)) begin
         cfg.cells_x = COUNT_W'(MAX_CELLS_X);
      end
      cfg.cells_y  = (cells_y_ff == '0) ? COUNT_W'(1) : COUNT_W'(cells_y_ff);
      if (cfg.cells_y > COUNT_W'(MAX_CELLS_Y)) begin
         cfg.cells_y = COUNT_W'(MAX_CELLS_Y);
      end
      cfg.cells_z  = COUNT_W'(GRID_Z_CELLS);
   end

   gcrb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (push_data)
   );

   gcrb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (pop_data),
      .full      (q_full),
      .stat      (q_stat)
   );

   gcrb_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_data  (pop_data),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

   // queue bookkeeping between front and back
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.push |-> !q_stat.full)
      else $error("range pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_stat.pop |-> !q_stat.empty)
      else $error("range popped from an empty queue");

   a_level_up: assert property (@(posedge clock) disable iff (reset)
      (q_stat.push && !q_stat.pop) |=> (q_stat.level == $past(q_stat.level) + LEVEL_W'(1)))
      else $error("queue level did not follow a push");

endmodule
